### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the sound generator modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The check is active only while reset is released.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// The expression must hold at every clock edge, including during reset.
`define ASSERT_ALWAYS(label, clk, expr) \
    label: assert property (@(posedge clk) (expr)) \
        else $error("invariant failed");

`endif

### sv/tvpsg_pkg.sv
// ----------------------------------------------------------------------------
// tvpsg_pkg
// Types and constants shared by the three-voice sound generator modules.
// ----------------------------------------------------------------------------
package tvpsg_pkg;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_SELECT = 2'd1,
        ACT_WRITE  = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    localparam logic [3:0] REG_TONE_A_FINE   = 4'd0;
    localparam logic [3:0] REG_TONE_A_COARSE = 4'd1;
    localparam logic [3:0] REG_TONE_B_FINE   = 4'd2;
    localparam logic [3:0] REG_TONE_B_COARSE = 4'd3;
    localparam logic [3:0] REG_TONE_C_FINE   = 4'd4;
    localparam logic [3:0] REG_TONE_C_COARSE = 4'd5;
    localparam logic [3:0] REG_NOISE_PERIOD  = 4'd6;
    localparam logic [3:0] REG_MIXER         = 4'd7;
    localparam logic [3:0] REG_VOL_A         = 4'd8;
    localparam logic [3:0] REG_VOL_B         = 4'd9;
    localparam logic [3:0] REG_VOL_C         = 4'd10;
    localparam logic [3:0] REG_ENV_FINE      = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE    = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE     = 4'd13;

    localparam int NUM_VOICES = 3;
    localparam int NUM_REGS   = 16;

    localparam logic [3:0]  AMP_MAX      = 4'd15;
    localparam logic [3:0]  AMP_MIN      = 4'd0;
    localparam logic [16:0] LFSR_INIT    = 17'h1FFFF;
    localparam logic [15:0] TONE_RESET   = 16'd16;
    localparam logic [8:0]  NOISE_RESET  = 9'd16;
    localparam logic [19:0] ENV_RESET    = 20'd16;

    typedef struct packed {
        logic [2:0]      tone_square;
        logic            noise_bit;
        logic [3:0]      env_amp;
        logic [5:0]      mixer_gate;
        logic [2:0][4:0] volume;
    } gen_status_t;

endpackage

### sv/three_voice_tone_noise_envelope_psg.sv
// ----------------------------------------------------------------------------
// three_voice_tone_noise_envelope_psg
// Three-voice tone, noise and envelope sound generator behind sixteen byte
// registers. Every input beat (tick, select, write or read) yields one result
// beat carrying read data, the per-voice gated amplitudes and the active flag.
// The block takes one beat per clock cycle unless a waiting result stalls it: an
// input register, then a combinational state update whose longest path is the
// 20-bit envelope countdown compare and reload, written straight into the
// result register. A result waiting on the output does not stop an empty input
// register from filling. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_voice_tone_noise_envelope_psg
    import tvpsg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [3:0] s_reg_index,
    input  logic [7:0] s_data_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic [3:0] m_level_a,
    output logic [3:0] m_level_b,
    output logic [3:0] m_level_c,
    output logic       m_active_flag
);

    logic        in_valid_reg;
    action_t     in_action_reg;
    logic [3:0]  in_index_reg;
    logic [7:0]  in_data_reg;
    logic        m_valid_reg;
    logic [7:0]  read_data_reg;
    logic [3:0]  level_a_reg, level_b_reg, level_c_reg;
    logic        active_reg;

    logic        go;
    logic [7:0]  rd_data;
    logic        active_next;
    gen_status_t status_next;
    logic [3:0]  lvl_a, lvl_b, lvl_c;

    assign go      = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || go;

    tvpsg_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .go          (go),
        .action      (in_action_reg),
        .reg_index   (in_index_reg),
        .data_in     (in_data_reg),
        .rd_data     (rd_data),
        .active_next (active_next),
        .status_next (status_next)
    );

    tvpsg_mixer u_mixer (
        .status  (status_next),
        .level_a (lvl_a),
        .level_b (lvl_b),
        .level_c (lvl_c)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= action_t'(s_action);
            in_index_reg  <= s_reg_index;
            in_data_reg   <= s_data_in;
        end
        if (go) begin
            read_data_reg <= rd_data;
            level_a_reg   <= lvl_a;
            level_b_reg   <= lvl_b;
            level_c_reg   <= lvl_c;
            active_reg    <= active_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_data   = read_data_reg;
    assign m_level_a     = level_a_reg;
    assign m_level_b     = level_b_reg;
    assign m_level_c     = level_c_reg;
    assign m_active_flag = active_reg;

    `ASSERT_CLK(a_go_gives_result, aclk, aresetn, go |=> m_valid_reg)
    `ASSERT_CLK(a_stalled_input_holds, aclk, aresetn,
        (in_valid_reg && !go) |=> (in_valid_reg && $stable(in_index_reg) &&
            $stable(in_data_reg)))

endmodule

### sv/tvpsg_core.sv
// ----------------------------------------------------------------------------
// tvpsg_core
// Register file, tone dividers, noise LFSR and envelope sequencer. One beat
// updates the whole state at once, from next-state logic into the registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tvpsg_core
    import tvpsg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        go,
    input  action_t     action,
    input  logic [3:0]  reg_index,
    input  logic [7:0]  data_in,
    output logic [7:0]  rd_data,
    output logic        active_next,
    output gen_status_t status_next
);

    logic [7:0]  rf_reg [NUM_REGS];
    logic [7:0]  rf_next [NUM_REGS];
    logic [3:0]  sel_idx_reg, sel_idx_next;
    logic        sel_valid_reg, sel_valid_next;
    logic        active_reg;
    logic [15:0] tone_per_reg [NUM_VOICES];
    logic [15:0] tone_per_next [NUM_VOICES];
    logic [15:0] tone_cd_reg [NUM_VOICES];
    logic [15:0] tone_cd_next [NUM_VOICES];
    logic [2:0]  tone_sq_reg, tone_sq_next;
    logic [8:0]  noise_per_reg, noise_per_next;
    logic [8:0]  noise_cd_reg, noise_cd_next;
    logic [16:0] lfsr_reg, lfsr_next;
    logic        noise_bit_reg, noise_bit_next;
    logic [19:0] env_per_reg, env_per_next;
    logic [19:0] env_cd_reg, env_cd_next;
    logic [3:0]  env_amp_reg, env_amp_next;
    logic        env_rising_reg, env_rising_next;
    logic [2:0]  env_shape_reg, env_shape_next;
    logic        env_frozen_reg, env_frozen_next;

    always_comb begin
        logic [7:0]  wr_val;
        logic [1:0]  ch;
        logic [11:0] tp;
        logic [15:0] tper;
        logic [4:0]  np;
        logic [8:0]  nper;
        logic [15:0] ep;
        logic [19:0] eper;
        logic        attack;

        rf_next           = rf_reg;
        sel_idx_next      = sel_idx_reg;
        sel_valid_next    = sel_valid_reg;
        active_next       = active_reg;
        tone_per_next     = tone_per_reg;
        tone_cd_next      = tone_cd_reg;
        tone_sq_next      = tone_sq_reg;
        noise_per_next    = noise_per_reg;
        noise_cd_next     = noise_cd_reg;
        lfsr_next         = lfsr_reg;
        noise_bit_next    = noise_bit_reg;
        env_per_next      = env_per_reg;
        env_cd_next       = env_cd_reg;
        env_amp_next      = env_amp_reg;
        env_rising_next   = env_rising_reg;
        env_shape_next    = env_shape_reg;
        env_frozen_next   = env_frozen_reg;
        rd_data           = 8'd0;
        ch                = sel_idx_reg[2:1];
        attack            = rf_reg[REG_ENV_SHAPE][2];

        case (sel_idx_reg)
            REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE,
            REG_ENV_SHAPE: wr_val = {4'd0, data_in[3:0]};
            REG_NOISE_PERIOD, REG_VOL_A, REG_VOL_B,
            REG_VOL_C:     wr_val = {3'd0, data_in[4:0]};
            default:       wr_val = data_in;
        endcase

        tp   = {rf_next[{1'b0, ch, 1'b1}][3:0], rf_next[{1'b0, ch, 1'b0}]};
        tper = 16'd0;
        np   = 5'd0;
        nper = 9'd0;
        ep   = 16'd0;
        eper = 20'd0;

        if (go) begin
            unique case (action)
                ACT_TICK: begin
                    for (int i = 0; i < NUM_VOICES; i++) begin
                        if (tone_cd_reg[i] <= 16'd1) begin
                            tone_cd_next[i] = tone_per_reg[i];
                            tone_sq_next[i] = ~tone_sq_reg[i];
                        end else begin
                            tone_cd_next[i] = tone_cd_reg[i] - 16'd1;
                        end
                    end
                    if (env_cd_reg <= 20'd1) begin
                        env_cd_next = env_per_reg;
                        if (!env_frozen_reg) begin
                            if (env_rising_reg && env_amp_reg < AMP_MAX) begin
                                env_amp_next = env_amp_reg + 4'd1;
                            end else if (!env_rising_reg && env_amp_reg > AMP_MIN) begin
                                env_amp_next = env_amp_reg - 4'd1;
                            end else if (!env_shape_reg[2]) begin
                                env_amp_next    = AMP_MIN;
                                env_frozen_next = 1'b1;
                            end else if (env_shape_reg[0]) begin
                                env_frozen_next = 1'b1;
                                if (env_shape_reg[1]) begin
                                    env_amp_next = attack ? AMP_MIN : AMP_MAX;
                                end else begin
                                    env_amp_next = attack ? AMP_MAX : AMP_MIN;
                                end
                            end else begin
                                if (env_shape_reg[1]) begin
                                    env_rising_next = ~env_rising_reg;
                                    env_amp_next    = env_rising_reg ? AMP_MAX : AMP_MIN;
                                end else begin
                                    env_amp_next    = env_rising_reg ? AMP_MIN : AMP_MAX;
                                end
                            end
                        end
                    end else begin
                        env_cd_next = env_cd_reg - 20'd1;
                    end
                    if (noise_cd_reg <= 9'd1) begin
                        noise_cd_next  = noise_per_reg;
                        lfsr_next      = {lfsr_reg[0] ^ lfsr_reg[3], lfsr_reg[16:1]};
                        noise_bit_next = lfsr_reg[1];
                    end else begin
                        noise_cd_next = noise_cd_reg - 9'd1;
                    end
                end
                ACT_SELECT: begin
                    sel_idx_next   = reg_index;
                    sel_valid_next = 1'b1;
                    active_next    = 1'b1;
                end
                ACT_WRITE: begin
                    if (sel_valid_reg) begin
                        active_next           = 1'b1;
                        rf_next[sel_idx_reg]  = wr_val;
                        tp   = {rf_next[{1'b0, ch, 1'b1}][3:0], rf_next[{1'b0, ch, 1'b0}]};
                        tper = {((tp == 12'd0) ? 12'd1 : tp), 4'd0};
                        np   = rf_next[REG_NOISE_PERIOD][4:0];
                        nper = {((np == 5'd0) ? 5'd1 : np), 4'd0};
                        ep   = {rf_next[REG_ENV_COARSE], rf_next[REG_ENV_FINE]};
                        eper = {((ep == 16'd0) ? 16'd1 : ep), 4'd0};
                        if (sel_idx_reg <= REG_TONE_C_COARSE) begin
                            tone_per_next[ch] = tper;
                            if (tone_cd_reg[ch] == 16'd0 || tone_cd_reg[ch] > tper) begin
                                tone_cd_next[ch] = tper;
                            end
                        end else if (sel_idx_reg == REG_NOISE_PERIOD) begin
                            noise_per_next = nper;
                            if (noise_cd_reg == 9'd0 || noise_cd_reg > nper) begin
                                noise_cd_next = nper;
                            end
                        end else if (sel_idx_reg == REG_ENV_FINE ||
                                     sel_idx_reg == REG_ENV_COARSE) begin
                            env_per_next = eper;
                            env_cd_next  = eper;
                        end else if (sel_idx_reg == REG_ENV_SHAPE) begin
                            env_per_next    = eper;
                            env_cd_next     = eper;
                            env_shape_next  = {wr_val[3], wr_val[1], wr_val[0]};
                            env_rising_next = wr_val[2];
                            env_amp_next    = wr_val[2] ? AMP_MIN : AMP_MAX;
                            env_frozen_next = 1'b0;
                        end
                    end
                end
                ACT_READ: begin
                    if (sel_valid_reg) begin
                        rd_data = rf_reg[sel_idx_reg];
                    end
                end
                default: begin
                    rd_data = 8'd0;
                end
            endcase
        end
    end

    always_comb begin
        status_next.tone_square = tone_sq_next;
        status_next.noise_bit   = noise_bit_next;
        status_next.env_amp     = env_amp_next;
        status_next.mixer_gate  = rf_next[REG_MIXER][5:0];
        status_next.volume[0]   = rf_next[REG_VOL_A][4:0];
        status_next.volume[1]   = rf_next[REG_VOL_B][4:0];
        status_next.volume[2]   = rf_next[REG_VOL_C][4:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                rf_reg[i] <= 8'd0;
            end
            for (int i = 0; i < NUM_VOICES; i++) begin
                tone_per_reg[i] <= TONE_RESET;
                tone_cd_reg[i]  <= TONE_RESET;
            end
            sel_idx_reg      <= 4'd0;
            sel_valid_reg    <= 1'b0;
            active_reg       <= 1'b0;
            tone_sq_reg      <= 3'b111;
            noise_per_reg    <= NOISE_RESET;
            noise_cd_reg     <= NOISE_RESET;
            lfsr_reg         <= LFSR_INIT;
            noise_bit_reg    <= 1'b1;
            env_per_reg      <= ENV_RESET;
            env_cd_reg       <= ENV_RESET;
            env_amp_reg      <= AMP_MAX;
            env_rising_reg   <= 1'b0;
            env_shape_reg    <= 3'd0;
            env_frozen_reg   <= 1'b0;
        end else begin
            rf_reg           <= rf_next;
            tone_per_reg     <= tone_per_next;
            tone_cd_reg      <= tone_cd_next;
            sel_idx_reg      <= sel_idx_next;
            sel_valid_reg    <= sel_valid_next;
            active_reg       <= active_next;
            tone_sq_reg      <= tone_sq_next;
            noise_per_reg    <= noise_per_next;
            noise_cd_reg     <= noise_cd_next;
            lfsr_reg         <= lfsr_next;
            noise_bit_reg    <= noise_bit_next;
            env_per_reg      <= env_per_next;
            env_cd_reg       <= env_cd_next;
            env_amp_reg      <= env_amp_next;
            env_rising_reg   <= env_rising_next;
            env_shape_reg    <= env_shape_next;
            env_frozen_reg   <= env_frozen_next;
        end
    end

    `ASSERT_CLK(a_active_sticky, aclk, aresetn, active_reg |=> active_reg)
    `ASSERT_CLK(a_select_takes, aclk, aresetn,
        (go && action == ACT_SELECT) |=>
            (sel_valid_reg && active_reg && sel_idx_reg == $past(reg_index)))
    `ASSERT_CLK(a_frozen_holds, aclk, aresetn,
        (env_frozen_reg && !(go && action == ACT_WRITE)) |=> $stable(env_amp_reg))
    `ASSERT_CLK(a_counts_nonzero, aclk, aresetn,
        tone_cd_reg[0] != 16'd0 && tone_cd_reg[1] != 16'd0 && tone_cd_reg[2] != 16'd0 &&
        noise_cd_reg != 9'd0 && env_cd_reg != 20'd0)

endmodule

### sv/tvpsg_mixer.sv
// ----------------------------------------------------------------------------
// tvpsg_mixer
// Gates each voice with its tone and noise outputs, each bypassed when its mixer
// bit is set, and picks the fixed or envelope amplitude.
// ----------------------------------------------------------------------------
module tvpsg_mixer
    import tvpsg_pkg::*;
(
    input  gen_status_t status,
    output logic [3:0]  level_a,
    output logic [3:0]  level_b,
    output logic [3:0]  level_c
);

    logic [3:0] level [NUM_VOICES];

    always_comb begin
        for (int i = 0; i < NUM_VOICES; i++) begin
            if ((status.mixer_gate[i] | status.tone_square[i]) &&
                (status.mixer_gate[i + 3] | status.noise_bit)) begin
                level[i] = status.volume[i][4] ? status.env_amp : status.volume[i][3:0];
            end else begin
                level[i] = 4'd0;
            end
        end
    end

    assign level_a = level[0];
    assign level_b = level[1];
    assign level_c = level[2];

endmodule
